// ===== rtl/core/mcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfb_pkg
// Shared types, frame constants and the CRC-16/MODBUS byte update used by
// the motor command frame builder.
// ----------------------------------------------------------------------------
package mcfb_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN = 9;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_SYNC   = pos_t'(0);
  localparam pos_t POS_ID     = pos_t'(1);
  localparam pos_t POS_LSPD   = pos_t'(2);
  localparam pos_t POS_LPAD   = pos_t'(3);
  localparam pos_t POS_RSPD   = pos_t'(4);
  localparam pos_t POS_RPAD   = pos_t'(5);
  localparam pos_t POS_DIR    = pos_t'(6);
  localparam pos_t POS_CRC_LO = pos_t'(7);
  localparam pos_t POS_CRC_HI = pos_t'(8);

  // Fixed frame bytes
  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] FRAME_ID  = 8'h07;
  localparam logic [7:0] PAD_BYTE  = 8'h00;

  // Direction codes
  localparam logic [7:0] DIR_FWD   = 8'h50;
  localparam logic [7:0] DIR_LEFT  = 8'h10;
  localparam logic [7:0] DIR_RIGHT = 8'h40;
  localparam logic [7:0] DIR_NONE  = 8'h00;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Command queue depth between front and back
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Classified command handed from front to back
  typedef struct packed {
    logic [7:0] speed;
    logic [7:0] dir;
  } cmd_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mcfb_front.sv =====
// ----------------------------------------------------------------------------
// mcfb_front
// Holds the speed register and classifies each drive command into a speed
// byte and a direction byte for the command queue.
// ----------------------------------------------------------------------------
module mcfb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 go_forward,
  input  logic                 go_backward,
  input  logic                 turn_left,
  input  logic                 turn_right,
  input  logic signed [7:0]    front_sensor,
  input  logic signed [7:0]    rear_sensor,
  output mcfb_pkg::cmd_t       cmd
);
  import mcfb_pkg::*;

  logic [7:0] drive_speed_r;
  logic       front_ok;
  logic       rear_ok;
  logic       move_ok;

  // Hold the configured speed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_speed_r <= 8'h00;
    end else if (cfg_wr_en) begin
      drive_speed_r <= cfg_wr_data;
    end
  end

  // Gate motion on the matching sensor reading
  assign front_ok = (front_sensor > 8'sd0);
  assign rear_ok  = (rear_sensor > 8'sd0);
  assign move_ok  = ((go_forward || turn_left || turn_right) && front_ok) ||
                    (go_backward && rear_ok);

  // Classify: speed and prioritized direction
  always_comb begin
    cmd.speed = move_ok ? drive_speed_r : 8'h00;
    if (go_forward) begin
      cmd.dir = DIR_FWD;
    end else if (turn_left) begin
      cmd.dir = DIR_LEFT;
    end else if (turn_right) begin
      cmd.dir = DIR_RIGHT;
    end else begin
      cmd.dir = DIR_NONE;
    end
  end

endmodule

// ===== rtl/core/mcfb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// mcfb_cmd_fifo
// Short queue of classified commands between the front and the frame
// serializer, so each side can stall on its own.
// ----------------------------------------------------------------------------
module mcfb_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mcfb_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output mcfb_pkg::cmd_t    head_cmd,
  output mcfb_pkg::q_stat_t stat
);
  import mcfb_pkg::*;

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r;
  logic [CMD_PTR_W-1:0] wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r;
  logic [CMD_PTR_W-1:0] rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] count_r;
  logic [CMD_CNT_W-1:0] count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/mcfb_serializer.sv =====
// ----------------------------------------------------------------------------
// mcfb_serializer
// Takes one command from the queue and sends its nine frame bytes one per
// transfer, folding bytes 1..6 into the CRC as they go out.
// ----------------------------------------------------------------------------
module mcfb_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  mcfb_pkg::cmd_t    q_cmd,
  input  mcfb_pkg::q_stat_t q_stat,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_frame_byte,
  output logic              out_last_byte
);
  import mcfb_pkg::*;

  logic        active_r;
  logic        active_nxt;
  pos_t        pos_r;
  pos_t        pos_nxt;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  cmd_t        cmd_r;
  cmd_t        cmd_nxt;
  logic        xfer;
  logic        load;
  logic [7:0]  cur_byte;

  assign xfer = active_r && out_pop;
  assign load = (!active_r || (xfer && pos_r == POS_CRC_HI)) && !q_stat.empty;
  assign q_pop = load;

  // Select the byte at the current frame position
  always_comb begin
    case (pos_r)
      POS_SYNC:   cur_byte = SYNC_BYTE;
      POS_ID:     cur_byte = FRAME_ID;
      POS_LSPD:   cur_byte = cmd_r.speed;
      POS_LPAD:   cur_byte = PAD_BYTE;
      POS_RSPD:   cur_byte = cmd_r.speed;
      POS_RPAD:   cur_byte = PAD_BYTE;
      POS_DIR:    cur_byte = cmd_r.dir;
      POS_CRC_LO: cur_byte = crc_r[7:0];
      POS_CRC_HI: cur_byte = crc_r[15:8];
      default:    cur_byte = PAD_BYTE;
    endcase
  end

  assign out_empty      = !active_r;
  assign out_frame_byte = cur_byte;
  assign out_last_byte  = (pos_r == POS_CRC_HI);

  // Advance through the frame, load the next command at its end or when idle
  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    cmd_nxt    = cmd_r;
    if (xfer) begin
      if (pos_r >= POS_ID && pos_r <= POS_DIR) begin
        crc_nxt = crc_feed(crc_r, cur_byte);
      end
      if (pos_r == POS_CRC_HI) begin
        active_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      pos_nxt    = POS_SYNC;
      crc_nxt    = CRC_INIT;
      cmd_nxt    = q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= POS_SYNC;
      crc_r    <= CRC_INIT;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
    end
  end

  // Hold the command being sent
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== rtl/core/motor_command_frame_builder.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_builder
// A transferred command is registered in the command queue and then loaded
// into the serializer, which shows its first frame byte on the output.
// Throughput: one byte per cycle while out_pop stays high, set by the serializer;
// a 2-entry command queue lets inputs be taken while a frame is sent.
// Reset: synchronous, active low; clears the queue, the serializer and the
// speed register (to 0).
// ----------------------------------------------------------------------------
module motor_command_frame_builder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_go_forward,
  input  logic             in_go_backward,
  input  logic             in_turn_left,
  input  logic             in_turn_right,
  input  logic signed [7:0] in_front_sensor,
  input  logic signed [7:0] in_rear_sensor,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte
);
  import mcfb_pkg::*;

  cmd_t    front_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;
  logic    q_pop;

  // Classify incoming commands
  mcfb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .go_forward   (in_go_forward),
    .go_backward  (in_go_backward),
    .turn_left    (in_turn_left),
    .turn_right   (in_turn_right),
    .front_sensor (in_front_sensor),
    .rear_sensor  (in_rear_sensor),
    .cmd          (front_cmd)
  );

  // Queue classified commands
  mcfb_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  assign in_full = q_stat.full;

  // Send frames
  mcfb_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_cmd          (head_cmd),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

`ifndef SYNTHESIS
  // A frame continues after any transfer that is not its last byte
  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last_byte) |=> !out_empty)
    else $error("frame interrupted before last byte");

  // A new frame always opens with the sync byte
  a_frame_opens_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_last_byte) |=>
      (out_empty || out_frame_byte == SYNC_BYTE))
    else $error("frame did not open with sync byte");

  // With the serializer idle the queue cannot be full
  a_idle_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty |-> !in_full)
    else $error("queue full while serializer idle");

  // Only the queue head is taken, and only when one is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command taken from empty queue");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor command frame builder. Drive commands go
// in through the push/full queue port; every command is predicted as a
// nine-byte frame (sync, id, speeds, pads, direction, CRC-16/MODBUS) and
// each popped byte is checked against the oldest predicted byte. Directed
// corner commands come first, then random traffic over several speed
// settings, random gaps on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 6;
  localparam int unsigned PRINT_CAP   = 40;

  // One drive command as offered on the input port
  typedef struct {
    logic             fwd;
    logic             back;
    logic             left;
    logic             right;
    logic signed [7:0] front;
    logic signed [7:0] rear;
  } drive_cmd_t;

  // One expected frame byte
  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [7:0]       cfg_wr_data;
  logic             in_push;
  logic             in_full;
  logic             in_go_forward;
  logic             in_go_backward;
  logic             in_turn_left;
  logic             in_turn_right;
  logic signed [7:0] in_front_sensor;
  logic signed [7:0] in_rear_sensor;
  logic             out_empty;
  logic             out_pop;
  logic [7:0]       out_frame_byte;
  logic             out_last_byte;

  frame_byte_t frame_bytes_due[$];
  logic [7:0]  speed_setting;
  int unsigned mismatch_count;
  int unsigned rx_hold_left;
  bit          tx_idle_on;
  bit          rx_idle_on;

  motor_command_frame_builder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_go_forward   (in_go_forward),
    .in_go_backward  (in_go_backward),
    .in_turn_left    (in_turn_left),
    .in_turn_right   (in_turn_right),
    .in_front_sensor (in_front_sensor),
    .in_rear_sensor  (in_rear_sensor),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_frame_byte  (out_frame_byte),
    .out_last_byte   (out_last_byte)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: end the run as a failure when CYCLE_LIMIT runs out
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  // Gap length: mostly short, now and then long
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 2);
    if (pick < 19) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // CRC-16/MODBUS update, one byte, LSB first
  function automatic logic [15:0] modbus_crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      acc = {1'b0, acc[15:1]} ^ (acc[0] ? mcfb_pkg::CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  // Build the frame a command should produce and queue its bytes
  function automatic void queue_expected_frame(drive_cmd_t c);
    logic [7:0]  wheel;
    logic [7:0]  heading;
    logic [15:0] crc;
    logic [7:0]  frame [9];
    frame_byte_t fb;
    if ((c.fwd || c.left || c.right) && c.front > 0) begin
      wheel = speed_setting;
    end else if (c.back && c.rear > 0) begin
      wheel = speed_setting;
    end else begin
      wheel = 8'h00;
    end
    if (c.fwd) begin
      heading = mcfb_pkg::DIR_FWD;
    end else if (c.left) begin
      heading = mcfb_pkg::DIR_LEFT;
    end else if (c.right) begin
      heading = mcfb_pkg::DIR_RIGHT;
    end else begin
      heading = mcfb_pkg::DIR_NONE;
    end
    frame[0] = mcfb_pkg::SYNC_BYTE;
    frame[1] = mcfb_pkg::FRAME_ID;
    frame[2] = wheel;
    frame[3] = mcfb_pkg::PAD_BYTE;
    frame[4] = wheel;
    frame[5] = mcfb_pkg::PAD_BYTE;
    frame[6] = heading;
    // CRC covers everything between the sync byte and the CRC itself
    crc = mcfb_pkg::CRC_INIT;
    for (int k = 1; k < 7; k++) begin
      crc = modbus_crc_byte(crc, frame[k]);
    end
    frame[7] = crc[7:0];
    frame[8] = crc[15:8];
    for (int k = 0; k < 9; k++) begin
      fb.data = frame[k];
      fb.last = (k == 8);
      frame_bytes_due.push_back(fb);
    end
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
  endtask

  // Result side: pop with random stalls, plus a counted hold-off on request
  int unsigned rx_stall_left;
  initial begin
    out_pop <= 1'b0;
    rx_stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_pop <= 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_pop <= 1'b0;
        rx_stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        rx_stall_left = idle_length() - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Check each byte transfer; values sampled mid-cycle are those seen at the edge
  initial begin
    frame_byte_t want;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_empty === 1'b0 && out_pop === 1'b1) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch("unexpected byte", out_frame_byte, 8'h00);
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_frame_byte !== want.data) begin
            report_mismatch("frame_byte", out_frame_byte, want.data);
          end
          if (out_last_byte !== want.last) begin
            report_mismatch("last_byte", {7'b0, out_last_byte}, {7'b0, want.last});
          end
        end
      end
    end
  end

  // Offer one command and hold it until transfer; call at a rising edge
  task automatic send_command(drive_cmd_t c);
    int unsigned gap;
    in_push         <= 1'b1;
    in_go_forward   <= c.fwd;
    in_go_backward  <= c.back;
    in_turn_left    <= c.left;
    in_turn_right   <= c.right;
    in_front_sensor <= c.front;
    in_rear_sensor  <= c.rear;
    @(negedge clk);
    while (in_full !== 1'b0) @(negedge clk);
    queue_expected_frame(c);
    @(posedge clk);
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic drive_cmd_t make_cmd(logic f, logic b, logic l, logic r,
                                          logic [7:0] fs, logic [7:0] rs);
    drive_cmd_t c;
    c.fwd   = f;
    c.back  = b;
    c.left  = l;
    c.right = r;
    c.front = fs;
    c.rear  = rs;
    return c;
  endfunction

  // Sensor values leaning toward the sign boundaries
  function automatic logic [7:0] random_sensor();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'h01;
      4: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic drive_cmd_t random_cmd();
    return make_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    random_sensor(), random_sensor());
  endfunction

  // Stop offering, let every expected byte come out, then settle
  task automatic wait_frames_out();
    in_push <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the speed register; block must be idle
  task automatic set_drive_speed(logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    speed_setting = value;
  endtask

  // Speed register must come out of reset at zero
  task automatic test_reset_speed();
    send_command(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'h7F, 8'h7F));
    send_command(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'h01, 8'h01));
    wait_frames_out();
  endtask

  // Each flag alone and combined, sensors at and around the sign boundary
  task automatic test_directed_commands();
    set_drive_speed(8'hC8);
    send_command(make_cmd(1'b0, 1'b0, 1'b0, 1'b0, 8'h7F, 8'h7F));
    send_command(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'h01, 8'h00));
    send_command(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h7F));
    send_command(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'hFF, 8'h01));
    send_command(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'h7F, 8'h80));
    send_command(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'h80, 8'h00));
    send_command(make_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'h05, 8'h00));
    send_command(make_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'hFB, 8'h7F));
    send_command(make_cmd(1'b0, 1'b0, 1'b0, 1'b1, 8'h64, 8'h80));
    send_command(make_cmd(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h01));
    send_command(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'h80, 8'h01));
    send_command(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'h7F, 8'h00));
    send_command(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'h01, 8'h80));
    send_command(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h7F));
    // backward rule grants speed while forward picks the direction
    send_command(make_cmd(1'b1, 1'b1, 1'b0, 1'b0, 8'hFD, 8'h09));
    send_command(make_cmd(1'b0, 1'b0, 1'b1, 1'b1, 8'h07, 8'h00));
    send_command(make_cmd(1'b0, 1'b1, 1'b0, 1'b1, 8'hFF, 8'h01));
    send_command(make_cmd(1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00));
    send_command(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'h55, 8'hAA));
    wait_frames_out();
  endtask

  // Random commands over several speeds, one phase without any gaps
  task automatic test_random_traffic();
    logic [7:0] speeds [5];
    speeds[0] = 8'hFF;
    speeds[1] = 8'h00;
    speeds[2] = 8'h01;
    speeds[3] = 8'($urandom_range(2, 254));
    speeds[4] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 5; p++) begin
      set_drive_speed(speeds[p]);
      tx_idle_on = (p != 2);
      rx_idle_on = (p != 2);
      repeat (30) send_command(random_cmd());
      wait_frames_out();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold the receiver off while the sender keeps offering, so input stalls
  task automatic test_receiver_stall();
    set_drive_speed(8'h5A);
    tx_idle_on   = 1'b0;
    rx_hold_left = 300;
    repeat (10) send_command(random_cmd());
    tx_idle_on = 1'b1;
    wait_frames_out();
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= 8'h00;
    in_push         <= 1'b0;
    in_go_forward   <= 1'b0;
    in_go_backward  <= 1'b0;
    in_turn_left    <= 1'b0;
    in_turn_right   <= 1'b0;
    in_front_sensor <= 8'sh00;
    in_rear_sensor  <= 8'sh00;
    speed_setting   = 8'h00;
    mismatch_count  = 0;
    rx_hold_left    = 0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_speed();
    test_directed_commands();
    test_random_traffic();
    test_receiver_stall();

    if (frame_bytes_due.size() != 0) begin
      report_mismatch("missing bytes", 8'(frame_bytes_due.size()), 8'h00);
    end
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
